// ===== rtl/fvn_pkg.sv =====
`timescale 1ns / 1ps
package fvn_pkg;

	localparam int ROM_DEPTH = 256;
	localparam int RECIP_BITS = 24;

	typedef enum logic [1:0] {
		REG_SEED   = 2'd0,
		REG_OCTAVE = 2'd1,
		REG_FREQ   = 2'd2
	} cfg_index_t;

	localparam logic [7:0] SEED_RESET = 8'd0;
	localparam logic [3:0] OCTAVE_RESET = 4'd2;
	localparam logic [15:0] FREQ_RESET = 16'd6554;

	localparam logic [7:0] LATTICE_ROM [ROM_DEPTH] = '{
		8'd208,8'd34,8'd231,8'd213,8'd32,8'd248,8'd233,8'd56,8'd161,8'd78,8'd24,8'd140,
		8'd71,8'd48,8'd140,8'd254,8'd245,8'd255,8'd247,8'd247,8'd40,8'd185,8'd248,8'd251,
		8'd245,8'd28,8'd124,8'd204,8'd204,8'd76,8'd36,8'd1,8'd107,8'd28,8'd234,8'd163,
		8'd202,8'd224,8'd245,8'd128,8'd167,8'd204,8'd9,8'd92,8'd217,8'd54,8'd239,8'd174,
		8'd173,8'd102,8'd193,8'd189,8'd190,8'd121,8'd100,8'd108,8'd167,8'd44,8'd43,8'd77,
		8'd180,8'd204,8'd8,8'd81,8'd70,8'd223,8'd11,8'd38,8'd24,8'd254,8'd210,8'd210,
		8'd177,8'd32,8'd81,8'd195,8'd243,8'd125,8'd8,8'd169,8'd112,8'd32,8'd97,8'd53,
		8'd195,8'd13,8'd203,8'd9,8'd47,8'd104,8'd125,8'd117,8'd114,8'd124,8'd165,8'd203,
		8'd181,8'd235,8'd193,8'd206,8'd70,8'd180,8'd174,8'd0,8'd167,8'd181,8'd41,8'd164,
		8'd30,8'd116,8'd127,8'd198,8'd245,8'd146,8'd87,8'd224,8'd149,8'd206,8'd57,8'd4,
		8'd192,8'd210,8'd65,8'd210,8'd129,8'd240,8'd178,8'd105,8'd228,8'd108,8'd245,8'd148,
		8'd140,8'd40,8'd35,8'd195,8'd38,8'd58,8'd65,8'd207,8'd215,8'd253,8'd65,8'd85,
		8'd208,8'd76,8'd62,8'd3,8'd237,8'd55,8'd89,8'd232,8'd50,8'd217,8'd64,8'd244,
		8'd157,8'd199,8'd121,8'd252,8'd90,8'd17,8'd212,8'd203,8'd149,8'd152,8'd140,8'd187,
		8'd234,8'd177,8'd73,8'd174,8'd193,8'd100,8'd192,8'd143,8'd97,8'd53,8'd145,8'd135,
		8'd19,8'd103,8'd13,8'd90,8'd135,8'd151,8'd199,8'd91,8'd239,8'd247,8'd33,8'd39,
		8'd145,8'd101,8'd120,8'd99,8'd3,8'd186,8'd86,8'd99,8'd41,8'd237,8'd203,8'd111,
		8'd79,8'd220,8'd135,8'd158,8'd42,8'd30,8'd154,8'd120,8'd67,8'd87,8'd167,8'd135,
		8'd176,8'd183,8'd191,8'd253,8'd115,8'd184,8'd21,8'd233,8'd58,8'd129,8'd233,8'd142,
		8'd39,8'd128,8'd211,8'd118,8'd137,8'd139,8'd255,8'd114,8'd20,8'd218,8'd113,8'd154,
		8'd27,8'd127,8'd246,8'd250,8'd1,8'd8,8'd198,8'd250,8'd209,8'd92,8'd222,8'd173,
		8'd21,8'd88,8'd102,8'd219
	};

	// Q.24 reciprocal of the weight sum 2 - 2^(1-n), indexed by octave count n.
	localparam logic [RECIP_BITS:0] RECIP_TABLE [17] = '{
		'0,
		(RECIP_BITS+1)'((64'd1 << (RECIP_BITS + 0)) / 64'd1),
		(RECIP_BITS+1)'((64'd1 << (RECIP_BITS + 1)) / 64'd3),
		(RECIP_BITS+1)'((64'd1 << (RECIP_BITS + 2)) / 64'd7),
		(RECIP_BITS+1)'((64'd1 << (RECIP_BITS + 3)) / 64'd15),
		(RECIP_BITS+1)'((64'd1 << (RECIP_BITS + 4)) / 64'd31),
		(RECIP_BITS+1)'((64'd1 << (RECIP_BITS + 5)) / 64'd63),
		(RECIP_BITS+1)'((64'd1 << (RECIP_BITS + 6)) / 64'd127),
		(RECIP_BITS+1)'((64'd1 << (RECIP_BITS + 7)) / 64'd255),
		(RECIP_BITS+1)'((64'd1 << (RECIP_BITS + 8)) / 64'd511),
		(RECIP_BITS+1)'((64'd1 << (RECIP_BITS + 9)) / 64'd1023),
		(RECIP_BITS+1)'((64'd1 << (RECIP_BITS + 10)) / 64'd2047),
		(RECIP_BITS+1)'((64'd1 << (RECIP_BITS + 11)) / 64'd4095),
		(RECIP_BITS+1)'((64'd1 << (RECIP_BITS + 12)) / 64'd8191),
		(RECIP_BITS+1)'((64'd1 << (RECIP_BITS + 13)) / 64'd16383),
		(RECIP_BITS+1)'((64'd1 << (RECIP_BITS + 14)) / 64'd32767),
		(RECIP_BITS+1)'((64'd1 << (RECIP_BITS + 15)) / 64'd65535)
	};

endpackage

// ===== rtl/fvn_octave.sv =====
`timescale 1ns / 1ps
// One octave: hash, smoothstep and bilinear blend over four register stages.
module fvn_octave #(
	parameter int FRAC_BITS = 16
) (
	input  logic                   clk,
	input  logic [7:0]             seed,
	input  logic [7:0]             xi,
	input  logic [7:0]             yi,
	input  logic [FRAC_BITS-1:0]   fx,
	input  logic [FRAC_BITS-1:0]   fy,
	output logic [FRAC_BITS+7:0]   sample
);
	localparam int F = FRAC_BITS;
	localparam logic [F+1:0] THREE = (F+2)'(3) << F;
	localparam logic [F:0] ONE = (F+1)'(1) << F;

	// Stage 1: row hash and squares of the fractions.
	logic [7:0] row0_s1, row1_s1, xi_s1;
	logic [F-1:0] fx_s1, fy_s1, sx2_s1, sy2_s1;
	logic [2*F-1:0] sqx, sqy;
	assign sqx = {{F{1'b0}}, fx} * {{F{1'b0}}, fx};
	assign sqy = {{F{1'b0}}, fy} * {{F{1'b0}}, fy};
	always_ff @(posedge clk) begin
		row0_s1 <= fvn_pkg::LATTICE_ROM[yi + seed];
		row1_s1 <= fvn_pkg::LATTICE_ROM[yi + seed + 8'd1];
		xi_s1 <= xi;
		fx_s1 <= fx;
		fy_s1 <= fy;
		sx2_s1 <= sqx[2*F-1:F];
		sy2_s1 <= sqy[2*F-1:F];
	end

	// Stage 2: corner lookup and smoothstep weights.
	logic [7:0] c00_s2, c10_s2, c01_s2, c11_s2;
	logic [F:0] wx_s2, wy_s2;
	logic [2*F+1:0] px, py;
	assign px = {{(F+2){1'b0}}, sx2_s1} * {{F{1'b0}}, THREE - {1'b0, fx_s1, 1'b0}};
	assign py = {{(F+2){1'b0}}, sy2_s1} * {{F{1'b0}}, THREE - {1'b0, fy_s1, 1'b0}};
	always_ff @(posedge clk) begin
		c00_s2 <= fvn_pkg::LATTICE_ROM[row0_s1 + xi_s1];
		c10_s2 <= fvn_pkg::LATTICE_ROM[row0_s1 + xi_s1 + 8'd1];
		c01_s2 <= fvn_pkg::LATTICE_ROM[row1_s1 + xi_s1];
		c11_s2 <= fvn_pkg::LATTICE_ROM[row1_s1 + xi_s1 + 8'd1];
		wx_s2 <= px[2*F:F];
		wy_s2 <= py[2*F:F];
	end

	// Stage 3: blends along x, kept in Q8.F.
	logic [F+7:0] ax_s3, bx_s3;
	logic [F:0] wy_s3;
	logic [F:0] wxn;
	assign wxn = ONE - wx_s2;
	always_ff @(posedge clk) begin
		ax_s3 <= (F+8)'(c00_s2 * wxn + c10_s2 * wx_s2);
		bx_s3 <= (F+8)'(c01_s2 * wxn + c11_s2 * wx_s2);
		wy_s3 <= wy_s2;
	end

	// Stage 4: blend along y.
	logic [2*F+8:0] yb;
	logic [F:0] wyn;
	assign wyn = ONE - wy_s3;
	assign yb = (2*F+9)'(ax_s3 * wyn) + (2*F+9)'(bx_s3 * wy_s3);
	always_ff @(posedge clk) begin
		sample <= yb[2*F+7:F];
	end
endmodule

// ===== rtl/fractal_value_noise_2d.sv =====
`timescale 1ns / 1ps
// Fractal value noise: one sample enters each cycle when start is high and busy is low;
// busy is always low. noise_value appears with done high once its item has passed
// the registered scale multiply, four-stage octave units, a weighting stage, a summing
// stage, a two-stage reciprocal multiply, shift, saturation and an output
// register. Results are in order and cannot be held off. Configuration must be written
// only when no item is in flight.
module fractal_value_noise_2d #(
	parameter int COORD_BITS = 16,
	parameter int FRAC_BITS = 16,
	parameter int MAX_OCTAVES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [15:0] x_coord,
	input  logic [15:0] y_coord,
	output logic        done,
	output logic [15:0] noise_value,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	localparam int F = FRAC_BITS;
	localparam int CW = COORD_BITS + FRAC_BITS;
	localparam int SW = F + 8;
	localparam int AW = SW + 4;
	localparam int LAT = 12;

	logic [7:0] seed_q;
	logic [3:0] oct_q;
	logic [15:0] freq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= fvn_pkg::SEED_RESET;
			oct_q <= fvn_pkg::OCTAVE_RESET;
			freq_q <= fvn_pkg::FREQ_RESET;
		end else if (cfg_we) begin
			case (fvn_pkg::cfg_index_t'(cfg_index))
				fvn_pkg::REG_SEED:   seed_q <= cfg_data[7:0];
				fvn_pkg::REG_OCTAVE: oct_q <= cfg_data[3:0];
				fvn_pkg::REG_FREQ:   freq_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	logic go;
	assign go = start && !busy;
	logic [LAT-1:0] vld_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else vld_q <= {vld_q[LAT-2:0], go};
	end
	assign done = vld_q[LAT-1];

	// Clamped octave count.
	logic [4:0] nclamp;
	always_comb begin
		if (oct_q == 4'd0) nclamp = 5'd1;
		else if (int'(oct_q) > MAX_OCTAVES) nclamp = 5'(MAX_OCTAVES);
		else nclamp = {1'b0, oct_q};
	end

	// Stage 1: scale coordinates.
	logic [CW-1:0] px_s1, py_s1;
	logic [31:0] mx, my;
	logic [CW+15:0] ex, ey;
	assign mx = x_coord * freq_q;
	assign my = y_coord * freq_q;
	always_comb begin
		if (F >= 16) begin
			ex = (CW+16)'(mx) << (F - 16);
			ey = (CW+16)'(my) << (F - 16);
		end else begin
			ex = (CW+16)'(mx) >> (16 - F);
			ey = (CW+16)'(my) >> (16 - F);
		end
	end
	always_ff @(posedge clk) begin
		px_s1 <= ex[CW-1:0];
		py_s1 <= ey[CW-1:0];
	end

	// Octave units in parallel lanes, four stages each.
	logic [SW-1:0] samp [MAX_OCTAVES];
	genvar g;
	generate
		for (g = 0; g < MAX_OCTAVES; g++) begin : g_oct
			logic [CW-1:0] sx, sy;
			assign sx = px_s1 << g;
			assign sy = py_s1 << g;
			fvn_octave #(.FRAC_BITS(F)) u_oct (
				.clk(clk), .seed(seed_q),
				.xi(sx[F+7:F]), .yi(sy[F+7:F]),
				.fx(sx[F-1:0]), .fy(sy[F-1:0]),
				.sample(samp[g])
			);
		end
	endgenerate

	// Stage 6: weight and mask each lane; stage 7: sum.
	logic [SW-1:0] part_s6 [MAX_OCTAVES];
	logic [AW-1:0] acc_s7;
	logic [AW-1:0] sum;
	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_OCTAVES; i++)
			part_s6[i] <= (i < int'(nclamp)) ? (samp[i] >> i) : '0;
	end
	always_comb begin
		sum = '0;
		for (int i = 0; i < MAX_OCTAVES; i++) sum = sum + AW'(part_s6[i]);
	end
	always_ff @(posedge clk) acc_s7 <= sum;

	// Stages 8-9: reciprocal multiply split in two partial products.
	logic [fvn_pkg::RECIP_BITS:0] rcp;
	assign rcp = fvn_pkg::RECIP_TABLE[nclamp];
	logic [AW+12:0] plo_s8, phi_s8;
	always_ff @(posedge clk) begin
		plo_s8 <= acc_s7 * rcp[12:0];
		phi_s8 <= acc_s7 * rcp[fvn_pkg::RECIP_BITS:13];
	end
	logic [AW+25:0] prod_s9;
	always_ff @(posedge clk) prod_s9 <= (AW+26)'(plo_s8) + ((AW+26)'(phi_s8) << 13);

	// Stages 10-12: shift, saturate, output register.
	logic [AW+25:0] shr_s10;
	always_ff @(posedge clk) shr_s10 <= prod_s9 >> (F + 16);
	logic [15:0] sat_s11;
	always_ff @(posedge clk) sat_s11 <= (shr_s10 > (AW+26)'(16'hFFFF)) ? 16'hFFFF
		: shr_s10[15:0];
	always_ff @(posedge clk) noise_value <= sat_s11;
endmodule

// ===== rtl/fvn_checker.sv =====
`timescale 1ns / 1ps
module fvn_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##12 done) else $error("result missing");
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 12)) else $error("unexpected result");
endmodule

bind fractal_value_noise_2d fvn_checker u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done)
);

// ===== test/fractal_value_noise_2d_tb.sv =====
`timescale 1ns / 1ps
module fractal_value_noise_2d_tb;

	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE_CYCLES = 24;

	typedef enum logic [1:0] {
		OP_SAMPLE,
		OP_WRITE,
		OP_PAUSE
	} op_kind_t;

	typedef struct {
		op_kind_t    kind;
		logic [15:0] x;
		logic [15:0] y;
		int          gap;
		logic [1:0]  index;
		logic [15:0] data;
	} pending_op_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [15:0] x_coord;
	logic [15:0] y_coord;
	logic        done;
	logic [15:0] noise_value;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	pending_op_t op_q[$];
	logic [15:0] noise_q[$];
	logic [7:0]  seed;
	logic [3:0]  octaves;
	logic [15:0] freq;
	int          quiet;
	int          waited;
	int          errors;
	int          cycles;
	bit          no_gaps;

	fractal_value_noise_2d dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.x_coord(x_coord), .y_coord(y_coord), .done(done), .noise_value(noise_value),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic logic [63:0] smoothstep(logic [15:0] s);
		logic [63:0] sq;
		sq = (64'(s) * 64'(s)) >> 16;
		return (sq * (64'd196608 - 64'd2 * 64'(s))) >> 16;
	endfunction

	function automatic logic [63:0] mix(logic [63:0] a, logic [63:0] b, logic [63:0] w);
		return (a * (64'd65536 - w) + b * w) >> 16;
	endfunction

	function automatic logic [63:0] lattice(logic [7:0] cx, logic [7:0] cy);
		logic [7:0] row;
		logic [7:0] col;
		row = fvn_pkg::LATTICE_ROM[8'(cy + seed)];
		col = 8'(row + cx);
		return 64'(fvn_pkg::LATTICE_ROM[col]) << 16;
	endfunction

	function automatic logic [63:0] octave_value(logic [31:0] px, logic [31:0] py);
		logic [7:0]  xi;
		logic [7:0]  yi;
		logic [63:0] wx;
		logic [63:0] wy;
		xi = px[23:16];
		yi = py[23:16];
		wx = smoothstep(px[15:0]);
		wy = smoothstep(py[15:0]);
		return mix(mix(lattice(xi, yi), lattice(8'(xi + 1), yi), wx),
			mix(lattice(xi, 8'(yi + 1)), lattice(8'(xi + 1), 8'(yi + 1)), wx), wy);
	endfunction

	function automatic logic [15:0] predict_noise(logic [15:0] x, logic [15:0] y);
		logic [31:0] px;
		logic [31:0] py;
		logic [63:0] acc;
		logic [63:0] rcp;
		logic [63:0] scaled;
		int          n;
		px = 32'(x) * 32'(freq);
		py = 32'(y) * 32'(freq);
		n = int'(octaves);
		if (n < 1) n = 1;
		if (n > 8) n = 8;
		acc = 0;
		for (int i = 0; i < n; i++) begin
			acc += octave_value(px, py) >> i;
			px = px << 1;
			py = py << 1;
		end
		rcp = (64'd1 << (23 + n)) / ((64'd1 << n) - 64'd1);
		scaled = (acc * rcp) >> 32;
		return (scaled > 64'hFFFF) ? 16'hFFFF : scaled[15:0];
	endfunction

	// Driver: one item, register write or pause per head of op_q.
	always @(posedge clk or negedge arst_n) begin
		pending_op_t head;
		logic        nstart;
		logic        nwe;
		logic [15:0] nx;
		logic [15:0] ny;
		logic [1:0]  nidx;
		logic [15:0] ndata;
		if (!arst_n) begin
			start <= 1'b0;
			x_coord <= '0;
			y_coord <= '0;
			cfg_we <= 1'b0;
			cfg_index <= fvn_pkg::REG_SEED;
			cfg_data <= '0;
			seed = fvn_pkg::SEED_RESET;
			octaves = fvn_pkg::OCTAVE_RESET;
			freq = fvn_pkg::FREQ_RESET;
			quiet = 0;
			waited = 0;
		end else begin
			nstart = 1'b0;
			nwe = 1'b0;
			nx = x_coord;
			ny = y_coord;
			nidx = cfg_index;
			ndata = cfg_data;
			if (cfg_we) begin
				case (cfg_index)
					fvn_pkg::REG_SEED: seed = cfg_data[7:0];
					fvn_pkg::REG_OCTAVE: octaves = cfg_data[3:0];
					fvn_pkg::REG_FREQ: freq = cfg_data;
					default: ;
				endcase
			end
			if (start && !busy) begin
				noise_q.push_back(predict_noise(x_coord, y_coord));
				void'(op_q.pop_front());
			end
			if (noise_q.size() == 0 && !start && !cfg_we)
				quiet++;
			else
				quiet = 0;
			if (start && busy) begin
				nstart = 1'b1;
			end else if (op_q.size() > 0) begin
				head = op_q[0];
				case (head.kind)
					OP_SAMPLE: begin
						if (waited < head.gap) begin
							waited++;
						end else begin
							waited = 0;
							nstart = 1'b1;
							nx = head.x;
							ny = head.y;
						end
					end
					OP_WRITE: begin
						// Writes wait out the pipeline so no item sees a mixed setting.
						if (quiet >= SETTLE_CYCLES) begin
							nwe = 1'b1;
							nidx = head.index;
							ndata = head.data;
							void'(op_q.pop_front());
						end
					end
					default: begin
						if (quiet >= 1)
							void'(op_q.pop_front());
					end
				endcase
			end
			start <= nstart;
			x_coord <= nx;
			y_coord <= ny;
			cfg_we <= nwe;
			cfg_index <= nidx;
			cfg_data <= ndata;
		end
	end

	always @(posedge clk) begin
		logic [15:0] want;
		if (arst_n && done) begin
			if (noise_q.size() == 0) begin
				$display("%0t: unexpected noise_value %0d", $time, noise_value);
				errors++;
			end else begin
				want = noise_q.pop_front();
				if (noise_value !== want) begin
					$display("%0t: noise_value expected %0d actual %0d", $time, want,
						noise_value);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic add_sample(logic [15:0] x, logic [15:0] y);
		pending_op_t op;
		op.kind = OP_SAMPLE;
		op.x = x;
		op.y = y;
		op.gap = no_gaps ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10));
		op.index = fvn_pkg::REG_SEED;
		op.data = '0;
		op_q.push_back(op);
	endtask

	task automatic add_write(logic [1:0] index, logic [15:0] data);
		pending_op_t op;
		op.kind = OP_WRITE;
		op.x = '0;
		op.y = '0;
		op.gap = 0;
		op.index = index;
		op.data = data;
		op_q.push_back(op);
	endtask

	task automatic add_pause();
		pending_op_t op;
		op.kind = OP_PAUSE;
		op.x = '0;
		op.y = '0;
		op.gap = 0;
		op.index = fvn_pkg::REG_SEED;
		op.data = '0;
		op_q.push_back(op);
	endtask

	task automatic add_random(int count);
		logic [15:0] x;
		logic [15:0] y;
		for (int i = 0; i < count; i++) begin
			x = 16'($urandom);
			y = 16'($urandom);
			// Many terrain grids stay small; keep a share of nearby coordinates.
			if ($urandom_range(0, 2) == 0) begin
				x = 16'($urandom_range(0, 300));
				y = 16'($urandom_range(0, 300));
			end
			add_sample(x, y);
			if ($urandom_range(0, 60) == 0)
				add_pause();
		end
	endtask

	initial begin
		errors = 0;
		cycles = 0;
		no_gaps = 0;
		arst_n = 1'b0;

		// Reset setting first, extremes of the coordinates.
		add_sample(16'd0, 16'd0);
		add_sample(16'hFFFF, 16'hFFFF);
		add_sample(16'hFFFF, 16'd0);
		add_sample(16'd0, 16'hFFFF);
		add_sample(16'h5555, 16'hAAAA);
		add_sample(16'd10, 16'd11);
		add_write(fvn_pkg::REG_SEED, 16'hFFFF);
		add_write(fvn_pkg::REG_OCTAVE, 16'h0008);
		add_write(fvn_pkg::REG_FREQ, 16'hFFFF);
		add_sample(16'hFFFF, 16'hFFFF);
		add_sample(16'h0001, 16'h8000);
		add_sample(16'hAAAA, 16'h5555);
		// Octave count zero acts as one; counts above eight saturate.
		add_write(fvn_pkg::REG_OCTAVE, 16'h0000);
		add_write(fvn_pkg::REG_FREQ, 16'h0000);
		add_sample(16'h1234, 16'hFEDC);
		add_write(fvn_pkg::REG_FREQ, 16'h8001);
		add_sample(16'hFFFF, 16'h7FFF);
		add_write(fvn_pkg::REG_OCTAVE, 16'hFFFF);
		add_sample(16'hFFFF, 16'hFFFF);
		add_sample(16'h00FF, 16'h0100);
		add_write(fvn_pkg::REG_OCTAVE, 16'h0001);
		add_write(fvn_pkg::REG_SEED, 16'h0000);
		add_sample(16'h7FFF, 16'h0001);
		// A write to an index past the list must change nothing.
		add_write(REG_UNUSED, 16'hFFFF);
		add_sample(16'h4321, 16'h8765);
		add_pause();

		for (int phase = 0; phase < 10; phase++) begin
			add_write(fvn_pkg::REG_SEED, 16'($urandom));
			add_write(fvn_pkg::REG_OCTAVE, (phase == 0) ? 16'h0008 : (phase == 1) ? 16'h0001
				: 16'($urandom_range(0, 15)));
			add_write(fvn_pkg::REG_FREQ, (phase == 2) ? 16'hFFFF : (phase == 3) ? 16'h0001
				: 16'($urandom));
			no_gaps = (phase % 3 == 1);
			add_random(73);
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		do
			@(posedge clk);
		while (op_q.size() > 0 || noise_q.size() > 0 || quiet < SETTLE_CYCLES);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
